>>> rtl/smx_pkg.sv
package smx_pkg;

    localparam int MAX_LENGTH = 64;
    localparam int IDX_W = $clog2(MAX_LENGTH);
    localparam int CNT_W = IDX_W + 1;
    localparam logic [15:0] INV_TEMP_RESET = 16'd256;
    localparam logic [8:0] LOG2E_Q8 = 9'd369;

    typedef logic [15:0] t_rom [256];

    typedef enum logic [7:0] {
        S_LOAD = 8'b0000_0001,
        S_ERD  = 8'b0000_0010,
        S_EMU1 = 8'b0000_0100,
        S_EMU2 = 8'b0000_1000,
        S_EWR  = 8'b0001_0000,
        S_DRD  = 8'b0010_0000,
        S_DLD  = 8'b0100_0000,
        S_DIV  = 8'b1000_0000
    } t_state;

    typedef struct packed {
        logic load;
        logic exp_mul1;
        logic exp_mul2;
        logic exp_wr;
        logic div_load;
        logic div_step;
        logic out_take;
    } t_cmd;

    typedef struct packed {
        logic vec_end;
        logic idx_last;
        logic div_done;
        logic out_valid;
    } t_status;

    function automatic logic [63:0] sqrt_frac(logic [63:0] f);
        logic [63:0] s;
        logic [63:0] c;
        logic [127:0] sq;
        s = 64'd0;
        for (int b = 63; b >= 0; b--) begin
            c = s | (64'd1 << b);
            sq = {64'd0, c} * {64'd0, c};
            if (sq <= {f, 64'd0}) begin
                s = c;
            end
        end
        return s;
    endfunction

    function automatic t_rom build_rom();
        t_rom rom;
        logic [63:0] root [8];
        logic [63:0] a;
        logic [63:0] p;
        logic [127:0] w;
        logic have;
        a = 64'h8000_0000_0000_0000;
        for (int j = 7; j >= 0; j--) begin
            a = sqrt_frac(a);
            root[j] = a;
        end
        rom[0] = 16'hFFFF;
        for (int k = 1; k < 256; k++) begin
            p = 64'd0;
            have = 1'b0;
            for (int j = 0; j < 8; j++) begin
                if (((k >> j) & 1) != 0) begin
                    if (!have) begin
                        p = root[j];
                        have = 1'b1;
                    end else begin
                        w = {64'd0, p} * {64'd0, root[j]};
                        p = w[127:64];
                    end
                end
            end
            w = {64'd0, p} * 128'd65535 + (128'd1 << 63);
            rom[k] = w[79:64];
        end
        return rom;
    endfunction

    localparam t_rom EXP_ROM = build_rom();

endpackage

>>> rtl/smx_ctrl.sv
module smx_ctrl
    import smx_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    output logic    o_in_stall,
    input  logic    i_out_stall,
    input  t_status i_status,
    output t_cmd    o_cmd
);

    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_LOAD;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_in_stall = (r_state != S_LOAD) || i_status.out_valid;

    always_comb begin
        n_state = r_state;
        o_cmd = '0;
        unique case (r_state)
            S_LOAD: begin
                if (i_status.out_valid) begin
                    o_cmd.out_take = !i_out_stall;
                    if (!i_out_stall && !i_status.idx_last) begin
                        n_state = S_DRD;
                    end
                end else if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    if (i_status.vec_end) begin
                        n_state = S_ERD;
                    end
                end
            end
            S_ERD: n_state = S_EMU1;
            S_EMU1: begin
                o_cmd.exp_mul1 = 1'b1;
                n_state = S_EMU2;
            end
            S_EMU2: begin
                o_cmd.exp_mul2 = 1'b1;
                n_state = S_EWR;
            end
            S_EWR: begin
                o_cmd.exp_wr = 1'b1;
                n_state = i_status.idx_last ? S_DRD : S_ERD;
            end
            S_DRD: n_state = S_DLD;
            S_DLD: begin
                o_cmd.div_load = 1'b1;
                n_state = S_DIV;
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                if (i_status.div_done) begin
                    n_state = S_LOAD;
                end
            end
            default: n_state = S_LOAD;
        endcase
    end

    a_no_load_while_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.load |-> !i_status.out_valid)
        else $error("score taken while a result is pending");
    a_out_only_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_status.out_valid |-> r_state == S_LOAD)
        else $error("result pending outside the idle state");
    a_div_done_leaves: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV && i_status.div_done) |=> i_status.out_valid)
        else $error("divide finished without a result");

endmodule

>>> rtl/smx_dp.sv
module smx_dp
    import smx_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_valid,
    input  logic [15:0] i_cfg_data,
    input  logic [15:0] i_sample_value,
    input  logic        i_last_sample,
    input  t_cmd        i_cmd,
    output t_status     o_status,
    output logic [15:0] o_probability,
    output logic [IDX_W-1:0] o_element_index,
    output logic        o_last_result
);

    logic [15:0] r_inv_temp;
    logic [15:0] r_score_mem [MAX_LENGTH];
    logic [15:0] r_exp_mem [MAX_LENGTH];
    logic [15:0] r_score_rd;
    logic [15:0] r_exp_rd;
    logic [CNT_W-1:0] r_count;
    logic signed [15:0] r_max;
    logic [21:0] r_total;
    logic [IDX_W-1:0] r_idx;
    logic [31:0] r_prod;
    logic [24:0] r_u;
    logic [21:0] r_rem;
    logic [31:0] r_quo;
    logic [3:0] r_div_cnt;
    logic r_out_valid;
    logic [15:0] r_prob;
    logic [IDX_W-1:0] r_out_idx;
    logic r_out_last;

    logic [16:0] diff;
    logic [23:0] negt;
    logic [32:0] umul;
    logic [15:0] e_val;
    logic [21:0] n_rem;
    logic [31:0] n_quo;
    logic [22:0] trial;
    logic idx_last;

    assign idx_last = ({1'b0, r_idx} + CNT_W'(1)) == r_count;
    assign diff = {r_max[15], r_max} - {r_score_rd[15], r_score_rd};
    assign negt = 24'((33'(r_prod) + 33'd255) >> 8);
    assign umul = 33'(negt) * 33'(LOG2E_Q8);
    assign e_val = (r_u[24:12] != '0) ? 16'd0 : (EXP_ROM[r_u[7:0]] >> r_u[11:8]);

    always_comb begin
        n_rem = r_rem;
        n_quo = r_quo;
        for (int k = 0; k < 2; k++) begin
            trial = {n_rem, n_quo[31]};
            n_quo = {n_quo[30:0], 1'b0};
            if (trial >= {1'b0, r_total}) begin
                trial = trial - {1'b0, r_total};
                n_quo[0] = 1'b1;
            end
            n_rem = trial[21:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_score_mem[r_count[IDX_W-1:0]] <= i_sample_value;
        end
        r_score_rd <= r_score_mem[r_idx];
        if (i_cmd.exp_wr) begin
            r_exp_mem[r_idx] <= e_val;
        end
        r_exp_rd <= r_exp_mem[r_idx];
        if (i_cmd.exp_mul1) begin
            r_prod <= 32'(diff[15:0]) * 32'(r_inv_temp);
        end
        if (i_cmd.exp_mul2) begin
            r_u <= umul[32:8];
        end
        if (i_cmd.div_load) begin
            r_rem <= '0;
            r_quo <= {r_exp_rd, 16'd0};
        end else if (i_cmd.div_step) begin
            r_rem <= n_rem;
            r_quo <= n_quo;
        end
        if (i_cmd.div_step && r_div_cnt == 4'd15) begin
            r_prob <= (n_quo[31:16] != '0) ? 16'hFFFF : n_quo[15:0];
            r_out_idx <= r_idx;
            r_out_last <= idx_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_inv_temp <= INV_TEMP_RESET;
            r_count <= '0;
            r_max <= -16'sd32768;
            r_total <= '0;
            r_idx <= '0;
            r_div_cnt <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                r_inv_temp <= i_cfg_data;
            end
            if (i_cmd.load) begin
                r_count <= r_count + CNT_W'(1);
                if ($signed(i_sample_value) > r_max) begin
                    r_max <= $signed(i_sample_value);
                end
                r_idx <= '0;
            end
            if (i_cmd.exp_wr) begin
                r_total <= r_total + 22'(e_val);
                r_idx <= idx_last ? '0 : r_idx + IDX_W'(1);
            end
            if (i_cmd.div_load) begin
                r_div_cnt <= '0;
            end else if (i_cmd.div_step) begin
                r_div_cnt <= r_div_cnt + 4'd1;
                if (r_div_cnt == 4'd15) begin
                    r_out_valid <= 1'b1;
                end
            end
            if (i_cmd.out_take) begin
                r_out_valid <= 1'b0;
                if (r_out_last) begin
                    r_count <= '0;
                    r_max <= -16'sd32768;
                    r_total <= '0;
                    r_idx <= '0;
                end else begin
                    r_idx <= r_idx + IDX_W'(1);
                end
            end
        end
    end

    assign o_status.vec_end = i_last_sample || (r_count == CNT_W'(MAX_LENGTH - 1));
    assign o_status.idx_last = r_out_valid ? r_out_last : idx_last;
    assign o_status.div_done = i_cmd.div_step && (r_div_cnt == 4'd15);
    assign o_status.out_valid = r_out_valid;
    assign o_probability = r_prob;
    assign o_element_index = r_out_idx;
    assign o_last_result = r_out_last;

endmodule

>>> rtl/softmax_normalizer_top.sv
// Softmax with temperature over vectors of up to 64 signed Q7.8 scores. Scores are taken one
// per cycle; the one marked last, or the 64th, ends the vector. Then each element passes
// through the exponent pipeline (score memory read, two multiplies, table lookup), after
// which each probability goes through an exponent memory read, a divider load, a radix-4
// divide by the exponent sum, and the output transfer, which an output stall can hold. No
// new score is taken until the last probability of the vector has been transferred.
module softmax_normalizer_top
    import smx_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [15:0] i_cfg_data,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic signed [15:0] i_sample_value,
    input  logic        i_last_sample,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [15:0] o_probability,
    output logic [5:0]  o_element_index,
    output logic        o_last_result
);

    t_cmd    cmd;
    t_status status;

    assign o_cfg_ready = 1'b1;
    assign o_out_valid = status.out_valid;

    smx_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_out_stall (i_out_stall),
        .i_status    (status),
        .o_cmd       (cmd)
    );

    smx_dp u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_valid     (i_cfg_valid),
        .i_cfg_data      (i_cfg_data),
        .i_sample_value  (i_sample_value),
        .i_last_sample   (i_last_sample),
        .i_cmd           (cmd),
        .o_status        (status),
        .o_probability   (o_probability),
        .o_element_index (o_element_index),
        .o_last_result   (o_last_result)
    );

endmodule
